>>> src/i2crb_pkg.sv
// Shared types, codes and address map of the I2C register bank controller.
package i2crb_pkg;

  // Bank geometry
  localparam int BANK_DEPTH = 256;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Bus opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Classified command kinds
  typedef logic [2:0] kind_t;
  localparam kind_t K_NOP    = 3'd0;
  localparam kind_t K_PTR    = 3'd1;
  localparam kind_t K_OPEN   = 3'd2;
  localparam kind_t K_DATA   = 3'd3;
  localparam kind_t K_READ   = 3'd4;
  localparam kind_t K_SAMPLE = 3'd5;

  // Configuration register map
  localparam logic        CFG_IDX_SAMPLE_INTERVAL = 1'b0;
  localparam logic [15:0] SAMPLE_INTERVAL_RST     = 16'd100;

  // Fixed bank addresses
  localparam logic [7:0] FAN_ADDR       = 8'd101;
  localparam logic [7:0] POWER_ADDR     = 8'h52;
  localparam logic [7:0] PGOOD_ADDR     = 8'h51;
  localparam logic [7:0] RESET_ADDR     = 8'h54;
  localparam logic [7:0] MARK_ADDR      = 8'h60;
  localparam logic [7:0] TIME_ADDR0     = 8'hF0;
  localparam logic [7:0] TIME_ADDR1     = 8'hF1;
  localparam logic [7:0] TIME_ADDR2     = 8'hF2;
  localparam logic [7:0] TIME_ADDR3     = 8'hF3;
  localparam logic [7:0] TIME_MARK_ADDR = 8'hF4;
  localparam logic [7:0] MARK_VALUE     = 8'hFF;
  localparam logic [7:0] TIME_MARK_VAL  = 8'hF4;
  localparam logic [7:0] FAN_OFF        = 8'hFF;
  localparam logic [7:0] POWER_ON_CODE  = 8'h01;

  // Status registers kept in flops, written all at once by a sample
  localparam int SPEC_COUNT = 9;
  typedef logic [3:0] spec_idx_t;
  localparam spec_idx_t SP_PGOOD = 4'd0;
  localparam spec_idx_t SP_POWER = 4'd1;
  localparam spec_idx_t SP_RESET = 4'd2;
  localparam spec_idx_t SP_MARK  = 4'd3;
  localparam spec_idx_t SP_TIME0 = 4'd4;
  localparam spec_idx_t SP_TIME1 = 4'd5;
  localparam spec_idx_t SP_TIME2 = 4'd6;
  localparam spec_idx_t SP_TIME3 = 4'd7;
  localparam spec_idx_t SP_TMARK = 4'd8;
  localparam spec_idx_t SP_NONE  = 4'd9;

  // One classified bus word as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        power_good_pin;
    logic        reset_pin;
    logic [31:0] time_ms;
  } cmd_t;

  // Map a bank address onto the status flop set
  function automatic spec_idx_t spec_idx(input logic [7:0] addr);
    spec_idx_t idx;
    case (addr)
      PGOOD_ADDR:     idx = SP_PGOOD;
      POWER_ADDR:     idx = SP_POWER;
      RESET_ADDR:     idx = SP_RESET;
      MARK_ADDR:      idx = SP_MARK;
      TIME_ADDR0:     idx = SP_TIME0;
      TIME_ADDR1:     idx = SP_TIME1;
      TIME_ADDR2:     idx = SP_TIME2;
      TIME_ADDR3:     idx = SP_TIME3;
      TIME_MARK_ADDR: idx = SP_TMARK;
      default:        idx = SP_NONE;
    endcase
    return idx;
  endfunction

endpackage

>>> src/i2crb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/i2crb_front.sv
// Front end: accepts bus words and classifies them into commands.
module i2crb_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  input  logic              in_power_good_pin,
  input  logic              in_reset_pin,
  input  logic [31:0]       in_time_ms,
  input  logic              q_ready,
  output logic              q_push,
  output i2crb_pkg::cmd_t   q_cmd
);

  i2crb_pkg::kind_t kind;

  // Decode opcode and framing bits into a command kind
  always_comb begin
    case (in_opcode)
      i2crb_pkg::OP_WRITE: begin
        if (in_first_byte && in_last_byte) begin
          kind = i2crb_pkg::K_PTR;
        end else if (in_first_byte) begin
          kind = i2crb_pkg::K_OPEN;
        end else begin
          kind = i2crb_pkg::K_DATA;
        end
      end
      i2crb_pkg::OP_READ:   kind = i2crb_pkg::K_READ;
      i2crb_pkg::OP_SAMPLE: kind = i2crb_pkg::K_SAMPLE;
      default:              kind = i2crb_pkg::K_NOP;
    endcase
  end

  // Pack the word for the queue
  always_comb begin
    q_cmd.kind           = kind;
    q_cmd.data_byte      = in_data_byte;
    q_cmd.last_byte      = in_last_byte;
    q_cmd.power_good_pin = in_power_good_pin;
    q_cmd.reset_pin      = in_reset_pin;
    q_cmd.time_ms        = in_time_ms;
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

endmodule

>>> src/i2crb_queue.sv
// Short command queue between the front end and the execution back end.
module i2crb_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2crb_pkg::cmd_t push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output i2crb_pkg::cmd_t pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2crb_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/i2crb_back.sv
// Back end: executes commands against the register bank and drives results.
module i2crb_back #(
  parameter int PIXEL_COUNT = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2crb_pkg::cmd_t q_cmd,
  output logic            q_pop,
  input  logic [15:0]     sample_interval,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_read_data,
  output logic [7:0]      out_fan_duty,
  output logic            out_power_enable,
  output logic            out_pixels_updated
);

  localparam int          AW        = i2crb_pkg::BANK_AW;
  localparam logic [7:0]  PIX_LIMIT = 8'(PIXEL_COUNT);

  // Transaction and output state
  logic [7:0]  rp_r, rp_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  off_r, off_nxt;
  logic        open_r, open_nxt;
  logic [7:0]  fan_r, fan_nxt;
  logic        en_r, en_nxt;
  logic [31:0] last_t_r, last_t_nxt;
  logic [7:0]  spec_r   [i2crb_pkg::SPEC_COUNT];
  logic [7:0]  spec_nxt [i2crb_pkg::SPEC_COUNT];
  logic [i2crb_pkg::BANK_DEPTH-1:0] vld_r;

  // Result stage
  logic        s1_v_r;
  logic        s1_read_r;
  logic        s1_hit_r;
  logic [7:0]  s1_spval_r;
  logic        s1_vbit_r;
  logic        s1_pix_r;

  // Execution datapath
  logic                  pop;
  logic                  pix_mode;
  logic [9:0]            tri_addr;
  logic [7:0]            tgt;
  i2crb_pkg::spec_idx_t  tgt_sp;
  i2crb_pkg::spec_idx_t  rp_sp;
  logic                  rp_hit;
  logic [7:0]            rp_spval;
  logic                  do_data;
  logic                  do_end;
  logic [31:0]           age;
  logic                  take;
  logic [7:0]            pw_new;
  logic                  ram_we;
  logic                  ram_re;
  logic [7:0]            ram_dout;

  assign pop   = q_valid && (!s1_v_r || out_ready);
  assign q_pop = pop;

  // Target address: pixel data fills three bytes per pixel from the start
  assign pix_mode = start_r < PIX_LIMIT;
  assign tri_addr = {2'b00, start_r} + {1'b0, start_r, 1'b0} + {2'b00, off_r};
  assign tgt      = pix_mode ? tri_addr[7:0] : start_r;
  assign tgt_sp   = i2crb_pkg::spec_idx(tgt);

  assign do_data = pop && (q_cmd.kind == i2crb_pkg::K_DATA) && open_r;
  assign do_end  = do_data && q_cmd.last_byte;

  // Sample gate on wrapping elapsed time
  assign age  = q_cmd.time_ms - last_t_r;
  assign take = pop && (q_cmd.kind == i2crb_pkg::K_SAMPLE) && (age > {16'h0000, sample_interval});

  // Read pointer lookup in the status flops
  assign rp_sp    = i2crb_pkg::spec_idx(rp_r);
  assign rp_hit   = (rp_sp != i2crb_pkg::SP_NONE);
  assign rp_spval = rp_hit ? spec_r[rp_sp] : 8'h00;

  // Power register value once this word has been written
  assign pw_new = (do_data && (tgt_sp == i2crb_pkg::SP_POWER)) ? q_cmd.data_byte
                                                               : spec_r[i2crb_pkg::SP_POWER];

  assign ram_we = do_data && (tgt_sp == i2crb_pkg::SP_NONE);
  assign ram_re = pop && (q_cmd.kind == i2crb_pkg::K_READ);

  // Next-state logic for one executed word
  always_comb begin
    rp_nxt     = rp_r;
    start_nxt  = start_r;
    off_nxt    = off_r;
    open_nxt   = open_r;
    fan_nxt    = fan_r;
    en_nxt     = en_r;
    last_t_nxt = last_t_r;
    for (int i = 0; i < i2crb_pkg::SPEC_COUNT; i++) begin
      spec_nxt[i] = spec_r[i];
    end
    if (pop) begin
      case (q_cmd.kind)
        i2crb_pkg::K_PTR: begin
          rp_nxt   = q_cmd.data_byte;
          open_nxt = 1'b0;
        end
        i2crb_pkg::K_OPEN: begin
          start_nxt = q_cmd.data_byte;
          off_nxt   = 8'h00;
          open_nxt  = 1'b1;
        end
        i2crb_pkg::K_DATA: begin
          if (open_r) begin
            if (tgt_sp != i2crb_pkg::SP_NONE) begin
              spec_nxt[tgt_sp] = q_cmd.data_byte;
            end
            if (pix_mode) begin
              off_nxt = off_r + 8'h01;
            end
            if (q_cmd.last_byte) begin
              // The fan address is never in pixel range, so the word just
              // written is the fan register itself
              if (start_r == i2crb_pkg::FAN_ADDR) begin
                fan_nxt = ~q_cmd.data_byte;
              end
              if (start_r == i2crb_pkg::POWER_ADDR) begin
                en_nxt = (pw_new == i2crb_pkg::POWER_ON_CODE);
              end
              open_nxt = 1'b0;
            end
          end
        end
        i2crb_pkg::K_SAMPLE: begin
          if (take) begin
            spec_nxt[i2crb_pkg::SP_PGOOD] = {7'h00, q_cmd.power_good_pin};
            spec_nxt[i2crb_pkg::SP_POWER] = {7'h00, en_r};
            spec_nxt[i2crb_pkg::SP_RESET] = {7'h00, q_cmd.reset_pin};
            spec_nxt[i2crb_pkg::SP_MARK]  = i2crb_pkg::MARK_VALUE;
            spec_nxt[i2crb_pkg::SP_TIME0] = q_cmd.time_ms[7:0];
            spec_nxt[i2crb_pkg::SP_TIME1] = q_cmd.time_ms[15:8];
            spec_nxt[i2crb_pkg::SP_TIME2] = q_cmd.time_ms[23:16];
            spec_nxt[i2crb_pkg::SP_TIME3] = q_cmd.time_ms[31:24];
            spec_nxt[i2crb_pkg::SP_TMARK] = i2crb_pkg::TIME_MARK_VAL;
            last_t_nxt = q_cmd.time_ms;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= 8'h00;
      start_r  <= 8'h00;
      off_r    <= 8'h00;
      open_r   <= 1'b0;
      fan_r    <= i2crb_pkg::FAN_OFF;
      en_r     <= 1'b1;
      last_t_r <= 32'h0;
      for (int i = 0; i < i2crb_pkg::SPEC_COUNT; i++) begin
        spec_r[i] <= 8'h00;
      end
    end else begin
      rp_r     <= rp_nxt;
      start_r  <= start_nxt;
      off_r    <= off_nxt;
      open_r   <= open_nxt;
      fan_r    <= fan_nxt;
      en_r     <= en_nxt;
      last_t_r <= last_t_nxt;
      for (int i = 0; i < i2crb_pkg::SPEC_COUNT; i++) begin
        spec_r[i] <= spec_nxt[i];
      end
    end
  end

  // Mark bank entries as written; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[tgt[AW-1:0]] <= 1'b1;
    end
  end

  i2crb_ram #(
    .WIDTH (8),
    .DEPTH (i2crb_pkg::BANK_DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tgt[AW-1:0]),
    .wdata (q_cmd.data_byte),
    .re    (ram_re),
    .raddr (rp_r[AW-1:0]),
    .rdata (ram_dout)
  );

  // Result stage: load on execute, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pop) begin
      s1_v_r <= 1'b1;
    end else if (out_ready) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_read_r  <= (q_cmd.kind == i2crb_pkg::K_READ);
      s1_hit_r   <= rp_hit;
      s1_spval_r <= rp_spval;
      s1_vbit_r  <= vld_r[rp_r[AW-1:0]];
      s1_pix_r   <= do_end && pix_mode;
    end
  end

  // Fan and power state only move on execute, which also reloads the result stage
  assign out_valid          = s1_v_r;
  assign out_read_data      = !s1_read_r ? 8'h00 :
                              s1_hit_r   ? s1_spval_r :
                              s1_vbit_r  ? ram_dout : 8'h00;
  assign out_fan_duty       = fan_r;
  assign out_power_enable   = en_r;
  assign out_pixels_updated = s1_pix_r;

  // One bank port operation per word
  a_one_ram_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("bank written and read by the same word");

  // An accepted sample leaves the marker in place
  a_sample_mark: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (spec_r[i2crb_pkg::SP_MARK] == i2crb_pkg::MARK_VALUE))
    else $error("sample marker not stored");

  // Opening byte starts a fresh transaction at offset zero
  a_open_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (q_cmd.kind == i2crb_pkg::K_OPEN)) |=> (open_r && (off_r == 8'h00)))
    else $error("transaction not opened cleanly");

  // A stalled result keeps its word and the state behind it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_ready) |=> (s1_v_r && $stable(s1_pix_r) && $stable(fan_r)
                                && $stable(en_r)))
    else $error("result changed while stalled");

endmodule

>>> src/i2c_register_bank_controller.sv
// Top level of the I2C register bank controller: config port, front end, queue, back end.
//
// Takes one bus word per clock cycle sustained while out_ready is high, and returns one
// result word for each, in order. An accepted word is first stored in the queue, then
// executed against the bank from there, and its result is registered in the result stage
// before it is offered; the rate is set by the back end, which executes one word per
// cycle while its result stage is free or being taken, and touches at most one bank port
// for it. A queue of QUEUE_DEPTH words lets input keep flowing while a result waits.
// The 256-byte bank is a RAM whose entries carry written flags cleared at reset, so the
// bank reads as zero straight out of reset with no clearing pass; the status registers
// a sample fills live in flops. sample_interval sits at byte address 0 of the APB port
// and should only be written while the block is idle.
module i2c_register_bank_controller #(
  parameter int PIXEL_COUNT = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        in_power_good_pin,
  input  logic        in_reset_pin,
  input  logic [31:0] in_time_ms,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_fan_duty,
  output logic        out_power_enable,
  output logic        out_pixels_updated,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]     interval_r;
  logic            cfg_wr;
  logic            q_ready;
  logic            q_push;
  i2crb_pkg::cmd_t push_cmd;
  logic            q_valid;
  logic            q_pop;
  i2crb_pkg::cmd_t pop_cmd;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == i2crb_pkg::CFG_IDX_SAMPLE_INTERVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= i2crb_pkg::SAMPLE_INTERVAL_RST;
    end else if (cfg_wr) begin
      interval_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == i2crb_pkg::CFG_IDX_SAMPLE_INTERVAL) ? {16'h0000, interval_r}
                                                                   : 32'h0;

  i2crb_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .in_power_good_pin (in_power_good_pin),
    .in_reset_pin      (in_reset_pin),
    .in_time_ms        (in_time_ms),
    .q_ready           (q_ready),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  i2crb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  i2crb_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cmd              (pop_cmd),
    .q_pop              (q_pop),
    .sample_interval    (interval_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_fan_duty       (out_fan_duty),
    .out_power_enable   (out_power_enable),
    .out_pixels_updated (out_pixels_updated)
  );

endmodule
